### src/rret_pkg.sv
// ----------------------------------------------------------------------------
// Round-robin endpoint table package
// Shared types and codes for the endpoint table, its memory and its checker.
// ----------------------------------------------------------------------------
package rret_pkg;

    localparam int DEF_MAX_ENDPOINTS = 16;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_ERASE  = 2'd1;
    localparam logic [1:0] CMD_CHOOSE = 2'd2;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_REFUSED = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] port;
        logic [31:0] address;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] chosen_port;
        logic [31:0] chosen_address;
    } res_t;

    typedef struct packed {
        logic [15:0] port;
        logic [31:0] address;
    } entry_t;

endpackage

### src/rret_mem.sv
// ----------------------------------------------------------------------------
// Endpoint table memory
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module rret_mem #(
    parameter int DEPTH = rret_pkg::DEF_MAX_ENDPOINTS,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [AW-1:0]        wr_addr,
    input  rret_pkg::entry_t     wr_data,
    input  logic [AW-1:0]        rd_addr,
    output rret_pkg::entry_t     rd_data
);

    rret_pkg::entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

### src/round_robin_endpoint_table_top.sv
// ----------------------------------------------------------------------------
// Round-robin endpoint table
// Ordered circular table of port/address pairs with insert, erase and choose.
// ----------------------------------------------------------------------------
// Sequence: choose passes through the choose and finish states (straight to
// finish on an empty table); insert and erase search linearly through the
// single read port, and an erase then closes the gap entry by entry. An
// unused command code goes straight to finish. One item is in work at a
// time; a finished result waits in an output register while the next item
// is taken. Reset empties the table at once.
// ----------------------------------------------------------------------------
module round_robin_endpoint_table_top #(
    parameter int MAX_ENDPOINTS = rret_pkg::DEF_MAX_ENDPOINTS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    output logic             cmd_ready,
    input  rret_pkg::cmd_t   cmd_data,
    output logic             res_valid,
    input  logic             res_ready,
    output rret_pkg::res_t   res_data
);

    localparam int IDX_W = $clog2(MAX_ENDPOINTS);
    localparam int CNT_W = $clog2(MAX_ENDPOINTS + 1);
    localparam logic [CNT_W:0]   MAX_SUM  = (CNT_W + 1)'(MAX_ENDPOINTS);
    localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_ENDPOINTS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_ENDPOINTS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT,
        S_CHOOSE,
        S_FINISH
    } state_t;

    state_t              state_reg;
    rret_pkg::cmd_t      cmd_reg;
    logic [IDX_W-1:0]    front_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    iss_reg;
    logic [CNT_W-1:0]    pend_k_reg;
    logic                pend_reg;
    logic [1:0]          status_reg;
    rret_pkg::entry_t    chosen_reg;
    logic                res_valid_reg;
    rret_pkg::res_t      res_data_reg;

    rret_pkg::entry_t    key;
    rret_pkg::entry_t    rd_data;
    logic                hit;
    logic                more_search;
    logic                more_shift;
    logic [CNT_W-1:0]    iss_inc;
    logic [CNT_W-1:0]    rd_pos;
    logic [IDX_W-1:0]    rd_addr;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    rret_pkg::entry_t    wr_data;

    // Slot of a logical position; front + pos stays below twice the depth.
    function automatic logic [IDX_W-1:0] slot_of(logic [IDX_W-1:0] f,
                                                 logic [CNT_W-1:0] pos);
        logic [CNT_W:0] s;
        s = {{(CNT_W + 1 - IDX_W){1'b0}}, f} + {1'b0, pos};
        if (s >= MAX_SUM)
        begin
            s = s - MAX_SUM;
        end
        return s[IDX_W-1:0];
    endfunction

    assign cmd_ready = (state_reg == S_IDLE);
    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    always_comb
    begin
        key.port    = cmd_reg.port;
        key.address = cmd_reg.address;
        hit         = pend_reg && (rd_data == key);
        more_search = (iss_reg < count_reg);
        iss_inc     = iss_reg + 1'b1;
        more_shift  = (iss_inc < count_reg);

        // In idle the front entry is read so that a choose has it next cycle.
        case (state_reg)
            S_IDLE:  rd_pos = '0;
            S_SHIFT: rd_pos = iss_inc;
            default: rd_pos = iss_reg;
        endcase
        rd_addr = slot_of(front_reg, rd_pos);

        wr_en   = 1'b0;
        wr_addr = slot_of(front_reg, count_reg);
        wr_data = key;
        case (state_reg)
            S_SEARCH:
            begin
                if (!hit && !more_search && !pend_reg &&
                    cmd_reg.cmd == rret_pkg::CMD_INSERT && count_reg < MAX_CNT)
                begin
                    wr_en = 1'b1;
                end
            end
            S_SHIFT:
            begin
                if (pend_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = slot_of(front_reg, pend_k_reg);
                    wr_data = rd_data;
                end
            end
            S_CHOOSE:
            begin
                // A full table rotates by moving the front index alone.
                if (count_reg > CNT_W'(1) && count_reg < MAX_CNT)
                begin
                    wr_en   = 1'b1;
                    wr_data = rd_data;
                end
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    rret_mem #(
        .DEPTH (MAX_ENDPOINTS),
        .AW    (IDX_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cmd_reg       <= '0;
            front_reg     <= '0;
            count_reg     <= '0;
            iss_reg       <= '0;
            pend_k_reg    <= '0;
            pend_reg      <= 1'b0;
            status_reg    <= rret_pkg::ST_REFUSED;
            chosen_reg    <= '0;
            res_valid_reg <= 1'b0;
            res_data_reg  <= '0;
        end
        else
        begin
            // In finish the output register is reloaded instead.
            if (res_valid_reg && res_ready && state_reg != S_FINISH)
            begin
                res_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        cmd_reg    <= cmd_data;
                        iss_reg    <= '0;
                        pend_reg   <= 1'b0;
                        chosen_reg <= '0;
                        status_reg <= rret_pkg::ST_REFUSED;
                        case (cmd_data.cmd)
                            rret_pkg::CMD_INSERT: state_reg <= S_SEARCH;
                            rret_pkg::CMD_ERASE:  state_reg <= S_SEARCH;
                            rret_pkg::CMD_CHOOSE:
                            begin
                                if (count_reg == '0)
                                begin
                                    state_reg <= S_FINISH;
                                end
                                else
                                begin
                                    state_reg <= S_CHOOSE;
                                end
                            end
                            default: state_reg <= S_FINISH;
                        endcase
                    end
                end

                S_SEARCH:
                begin
                    if (hit)
                    begin
                        if (cmd_reg.cmd == rret_pkg::CMD_INSERT)
                        begin
                            status_reg <= rret_pkg::ST_REFUSED;
                            state_reg  <= S_FINISH;
                        end
                        else
                        begin
                            iss_reg   <= pend_k_reg;
                            pend_reg  <= 1'b0;
                            state_reg <= S_SHIFT;
                        end
                    end
                    else if (more_search)
                    begin
                        pend_reg   <= 1'b1;
                        pend_k_reg <= iss_reg;
                        iss_reg    <= iss_inc;
                    end
                    else if (!pend_reg)
                    begin
                        if (cmd_reg.cmd == rret_pkg::CMD_INSERT)
                        begin
                            if (count_reg >= MAX_CNT)
                            begin
                                status_reg <= rret_pkg::ST_FULL;
                            end
                            else
                            begin
                                count_reg  <= count_reg + 1'b1;
                                status_reg <= rret_pkg::ST_DONE;
                            end
                        end
                        else
                        begin
                            status_reg <= rret_pkg::ST_REFUSED;
                        end
                        state_reg <= S_FINISH;
                    end
                    else
                    begin
                        pend_reg <= 1'b0;
                    end
                end

                S_SHIFT:
                begin
                    if (more_shift)
                    begin
                        pend_reg   <= 1'b1;
                        pend_k_reg <= iss_reg;
                        iss_reg    <= iss_inc;
                    end
                    else
                    begin
                        pend_reg <= 1'b0;
                        if (!pend_reg)
                        begin
                            count_reg  <= count_reg - 1'b1;
                            status_reg <= rret_pkg::ST_DONE;
                            state_reg  <= S_FINISH;
                        end
                    end
                end

                S_CHOOSE:
                begin
                    chosen_reg <= rd_data;
                    status_reg <= rret_pkg::ST_DONE;
                    if (count_reg > CNT_W'(1))
                    begin
                        front_reg <= (front_reg == LAST_IDX) ? '0 : front_reg + 1'b1;
                    end
                    state_reg <= S_FINISH;
                end

                S_FINISH:
                begin
                    if (!res_valid_reg || res_ready)
                    begin
                        res_data_reg.status         <= status_reg;
                        res_data_reg.chosen_port    <= chosen_reg.port;
                        res_data_reg.chosen_address <= chosen_reg.address;
                        res_valid_reg               <= 1'b1;
                        state_reg                   <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

### src/rret_checker.sv
// ----------------------------------------------------------------------------
// Round-robin endpoint table checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module rret_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    input  logic             cmd_ready,
    input  rret_pkg::cmd_t   cmd_data,
    input  logic             res_valid,
    input  logic             res_ready,
    input  rret_pkg::res_t   res_data
);

    // A result held back by the consumer keeps its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_data))
        else $error("result changed while stalled");

    // Only one item is worked on at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("input taken while an item is in work");

    // A result that is not a success carries no endpoint.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.status != rret_pkg::ST_DONE
        |-> res_data.chosen_port == '0 && res_data.chosen_address == '0)
        else $error("endpoint reported on a failed command");

    // Status is always one of the defined codes.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_data.status == rret_pkg::ST_DONE ||
                      res_data.status == rret_pkg::ST_REFUSED ||
                      res_data.status == rret_pkg::ST_FULL)
        else $error("undefined status code");

endmodule

bind round_robin_endpoint_table_top rret_checker u_rret_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd_data  (cmd_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
);

### verif/round_robin_endpoint_table_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Round-robin endpoint table testbench
// Drives insert, erase, choose and unused commands through the valid/ready input
// channel, with random idle bursts on both sides, and checks every result
// transfer against a directed expected result or a cycle-free shadow of the circular endpoint table.
// ----------------------------------------------------------------------------
module round_robin_endpoint_table_top_test;

    localparam int TABLE_DEPTH = rret_pkg::DEF_MAX_ENDPOINTS;
    localparam int POOL_SIZE = 24;
    localparam int RANDOM_ITEMS = 900;
    localparam int QUIET_FROM = 780;
    localparam int SETTLE_CYCLES = 2 * TABLE_DEPTH + 8;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        rret_pkg::cmd_t item;
        bit             typed;
        rret_pkg::res_t result;
    } directed_row_t;

    logic clk;
    logic rst_n;
    logic cmd_valid;
    logic cmd_ready;
    rret_pkg::cmd_t cmd_data;
    logic res_valid;
    logic res_ready;
    rret_pkg::res_t res_data;

    // Shadow of the endpoint table, kept in the same circular layout.
    rret_pkg::entry_t shadow_slots [TABLE_DEPTH];
    logic [3:0]       shadow_front;
    logic [4:0]       shadow_count;

    rret_pkg::res_t   pending_responses [$];
    directed_row_t    directed_rows [$];
    rret_pkg::entry_t endpoint_pool [POOL_SIZE];
    int               error_count;
    bit               quiet_tail;

    round_robin_endpoint_table_top #(
        .MAX_ENDPOINTS(TABLE_DEPTH)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_data  (cmd_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #1000000;
        $display("round_robin_endpoint_table_top_test: done, errors");
        $finish;
    end

    function automatic int slot_at(int pos);
        return (int'(shadow_front) + pos) % TABLE_DEPTH;
    endfunction

    // Logical position of a stored pair, or the entry count when absent.
    function automatic int locate_pair(logic [15:0] port, logic [31:0] address);
        int k;
        for (k = 0; k < int'(shadow_count); k++)
        begin
            if (shadow_slots[slot_at(k)].port == port
                && shadow_slots[slot_at(k)].address == address)
                return k;
        end
        return int'(shadow_count);
    endfunction

    function automatic rret_pkg::res_t predict_endpoint_response(rret_pkg::cmd_t item);
        rret_pkg::res_t   r;
        rret_pkg::entry_t front;
        int               k;
        r = '0;
        r.status = rret_pkg::ST_REFUSED;
        case (item.cmd)
            rret_pkg::CMD_INSERT:
            begin
                if (locate_pair(item.port, item.address) < int'(shadow_count))
                    r.status = rret_pkg::ST_REFUSED;
                else if (int'(shadow_count) >= TABLE_DEPTH)
                    r.status = rret_pkg::ST_FULL;
                else
                begin
                    shadow_slots[slot_at(int'(shadow_count))] = '{item.port, item.address};
                    shadow_count = shadow_count + 5'd1;
                    r.status = rret_pkg::ST_DONE;
                end
            end
            rret_pkg::CMD_ERASE:
            begin
                k = locate_pair(item.port, item.address);
                if (k < int'(shadow_count))
                begin
                    // Close the gap so the remaining order is kept.
                    for (; k + 1 < int'(shadow_count); k++)
                        shadow_slots[slot_at(k)] = shadow_slots[slot_at(k + 1)];
                    shadow_count = shadow_count - 5'd1;
                    r.status = rret_pkg::ST_DONE;
                end
            end
            rret_pkg::CMD_CHOOSE:
            begin
                if (shadow_count != 5'd0)
                begin
                    front = shadow_slots[shadow_front];
                    r.chosen_port = front.port;
                    r.chosen_address = front.address;
                    if (shadow_count > 5'd1)
                    begin
                        if (int'(shadow_count) < TABLE_DEPTH)
                            shadow_slots[slot_at(int'(shadow_count))] = front;
                        shadow_front = shadow_front + 4'd1;
                    end
                    r.status = rret_pkg::ST_DONE;
                end
            end
            default:
                r.status = rret_pkg::ST_REFUSED;
        endcase
        return r;
    endfunction

    function automatic void add_row(logic [1:0] cmd, logic [15:0] port, logic [31:0] address,
                                    bit typed, logic [1:0] status,
                                    logic [15:0] chosen_port, logic [31:0] chosen_address);
        directed_row_t row;
        row.item = '{cmd, port, address};
        row.typed = typed;
        row.result = '{status, chosen_port, chosen_address};
        directed_rows.push_back(row);
    endfunction

    function automatic void build_directed_rows();
        int i;
        add_row(rret_pkg::CMD_CHOOSE, 16'h1234, 32'h8765_4321, 1,
                rret_pkg::ST_REFUSED, 16'h0, 32'h0);
        add_row(rret_pkg::CMD_ERASE,  16'h0000, 32'h0000_0000, 1,
                rret_pkg::ST_REFUSED, 16'h0, 32'h0);
        add_row(CMD_UNUSED,           16'hA5A5, 32'h5A5A_5A5A, 1,
                rret_pkg::ST_REFUSED, 16'h0, 32'h0);
        add_row(rret_pkg::CMD_INSERT, 16'h0000, 32'h0000_0000, 1,
                rret_pkg::ST_DONE,    16'h0, 32'h0);
        // A single entry is returned without changing the order.
        add_row(rret_pkg::CMD_CHOOSE, 16'hFFFF, 32'hFFFF_FFFF, 1,
                rret_pkg::ST_DONE,    16'h0, 32'h0);
        add_row(rret_pkg::CMD_INSERT, 16'hFFFF, 32'hFFFF_FFFF, 1,
                rret_pkg::ST_DONE,    16'h0, 32'h0);
        add_row(rret_pkg::CMD_INSERT, 16'h0000, 32'h0000_0000, 1,
                rret_pkg::ST_REFUSED, 16'h0, 32'h0);
        add_row(rret_pkg::CMD_ERASE,  16'h0000, 32'hFFFF_FFFF, 1,
                rret_pkg::ST_REFUSED, 16'h0, 32'h0);
        add_row(rret_pkg::CMD_CHOOSE, 16'h0000, 32'h0000_0000, 0,
                rret_pkg::ST_DONE,    16'h0, 32'h0);
        add_row(rret_pkg::CMD_ERASE,  16'hFFFF, 32'hFFFF_FFFF, 1,
                rret_pkg::ST_DONE,    16'h0, 32'h0);
        for (i = 0; i < TABLE_DEPTH - 1; i++)
            add_row(rret_pkg::CMD_INSERT, 16'h1000 + 16'(i), 32'h0A00_0000 + 32'(i),
                    1, rret_pkg::ST_DONE, 16'h0, 32'h0);
        add_row(rret_pkg::CMD_INSERT, 16'hBEEF, 32'hC0A8_0001, 1,
                rret_pkg::ST_FULL,    16'h0, 32'h0);
        // The duplicate check wins over the full check.
        add_row(rret_pkg::CMD_INSERT, 16'h1003, 32'h0A00_0003, 1,
                rret_pkg::ST_REFUSED, 16'h0, 32'h0);
        add_row(rret_pkg::CMD_CHOOSE, 16'h0000, 32'h0000_0000, 0,
                rret_pkg::ST_DONE,    16'h0, 32'h0);
        add_row(rret_pkg::CMD_ERASE,  16'h1005, 32'h0A00_0005, 1,
                rret_pkg::ST_DONE,    16'h0, 32'h0);
        add_row(rret_pkg::CMD_CHOOSE, 16'h0000, 32'h0000_0000, 0,
                rret_pkg::ST_DONE,    16'h0, 32'h0);
        add_row(rret_pkg::CMD_INSERT, 16'hBEEF, 32'hC0A8_0001, 1,
                rret_pkg::ST_DONE,    16'h0, 32'h0);
    endfunction

    // Pairs often share a port or an address with a neighbor, so that partial
    // matches are searched past.
    function automatic void refresh_endpoint_pool();
        int i;
        for (i = 0; i < POOL_SIZE; i++)
        begin
            endpoint_pool[i].port = 16'($urandom);
            endpoint_pool[i].address = $urandom;
            if (i > 0 && $urandom_range(0, 3) == 0)
                endpoint_pool[i].port = endpoint_pool[i - 1].port;
            else if (i > 0 && $urandom_range(0, 3) == 0)
                endpoint_pool[i].address = endpoint_pool[i - 1].address;
            if ($urandom_range(0, 11) == 0)
                endpoint_pool[i].port = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            if ($urandom_range(0, 11) == 0)
                endpoint_pool[i].address = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
        end
    endfunction

    // Mode 0 is balanced, mode 1 leans on filling, mode 2 on draining.
    function automatic rret_pkg::cmd_t pick_random_item(int mode);
        rret_pkg::cmd_t   item;
        int               roll;
        int               sub;
        int               insert_limit;
        int               erase_limit;
        rret_pkg::entry_t pair;
        case (mode)
            1:       begin insert_limit = 70; erase_limit = 82; end
            2:       begin insert_limit = 22; erase_limit = 70; end
            default: begin insert_limit = 40; erase_limit = 68; end
        endcase
        roll = $urandom_range(0, 99);
        item.port = 16'($urandom);
        item.address = $urandom;
        pair = endpoint_pool[$urandom_range(0, POOL_SIZE - 1)];
        if (roll < 4)
            item.cmd = CMD_UNUSED;
        else if (roll < insert_limit)
        begin
            item.cmd = rret_pkg::CMD_INSERT;
            if ($urandom_range(0, 3) != 0)
                {item.port, item.address} = pair;
        end
        else if (roll < erase_limit)
        begin
            item.cmd = rret_pkg::CMD_ERASE;
            sub = $urandom_range(0, 99);
            if (sub < 60 && shadow_count != 5'd0)
                {item.port, item.address} =
                    shadow_slots[slot_at($urandom_range(0, int'(shadow_count) - 1))];
            else if (sub < 85)
                {item.port, item.address} = pair;
        end
        else
            item.cmd = rret_pkg::CMD_CHOOSE;
        return item;
    endfunction

    // Presents one item and returns at the edge where it transfers.
    task automatic send_command(rret_pkg::cmd_t item, rret_pkg::res_t typed_result,
                                bit typed);
        int             gap;
        rret_pkg::res_t predicted;
        gap = 0;
        if (!quiet_tail && $urandom_range(0, 5) == 0)
            gap = $urandom_range(1, 14);
        @(negedge clk);
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_data <= item;
        @(posedge clk);
        while (!cmd_ready)
            @(posedge clk);
        predicted = predict_endpoint_response(item);
        pending_responses.push_back(typed ? typed_result : predicted);
    endtask

    task automatic wait_for_drain();
        @(negedge clk);
        cmd_valid <= 1'b0;
        while (pending_responses.size() != 0)
            @(posedge clk);
    endtask

    // Receiver side: ready drops in random bursts until the quiet tail.
    initial
    begin
        int stall_left;
        res_ready = 1'b0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (quiet_tail)
                res_ready <= 1'b1;
            else if (stall_left > 0)
            begin
                res_ready <= 1'b0;
                stall_left--;
            end
            else if ($urandom_range(0, 7) == 0)
            begin
                res_ready <= 1'b0;
                stall_left = $urandom_range(0, 13);
            end
            else
                res_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        rret_pkg::res_t want;
        if (rst_n && res_valid && res_ready)
        begin
            if (pending_responses.size() == 0)
            begin
                $error("result transfer with no command outstanding");
                error_count++;
            end
            else
            begin
                want = pending_responses.pop_front();
                if (res_data.status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, res_data.status);
                    error_count++;
                end
                if (res_data.chosen_port !== want.chosen_port)
                begin
                    $error("chosen_port: expected %h, actual %h",
                           want.chosen_port, res_data.chosen_port);
                    error_count++;
                end
                if (res_data.chosen_address !== want.chosen_address)
                begin
                    $error("chosen_address: expected %h, actual %h",
                           want.chosen_address, res_data.chosen_address);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        int i;
        int mode;
        rst_n = 1'b0;
        cmd_valid = 1'b0;
        cmd_data = '0;
        error_count = 0;
        quiet_tail = 1'b0;
        mode = 0;
        shadow_front = '0;
        shadow_count = '0;
        for (i = 0; i < TABLE_DEPTH; i++)
            shadow_slots[i] = '0;
        build_directed_rows();
        refresh_endpoint_pool();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[n])
            send_command(directed_rows[n].item, directed_rows[n].result,
                         directed_rows[n].typed);

        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 60 == 0)
                mode = $urandom_range(0, 2);
            if (i % 300 == 299)
                refresh_endpoint_pool();
            if (i % 150 == 75)
                wait_for_drain();
            if (i == QUIET_FROM)
                quiet_tail = 1'b1;
            send_command(pick_random_item(mode), '0, 0);
        end

        @(negedge clk);
        cmd_valid <= 1'b0;
        while (pending_responses.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("round_robin_endpoint_table_top_test: done, clean");
        else
            $display("round_robin_endpoint_table_top_test: done, errors");
        $finish;
    end

endmodule

### files.f
src/rret_pkg.sv
src/rret_mem.sv
src/round_robin_endpoint_table_top.sv
src/rret_checker.sv
verif/round_robin_endpoint_table_top_test.sv
